[sv/eptg_pkg.sv]
// Shared constants, types and elaboration-time functions of the epitrochoid point generator.
package eptg_pkg;

  // Default parameter values.
  localparam int MAX_STEPS_DEF     = 3000;
  localparam int PHASE_BITS_DEF    = 24;
  localparam int CORDIC_STAGES_DEF = 20;
  localparam int MIN_STEPS         = 10;

  // Divider widths: numerator magnitude and denominator bounds over the full parameter range.
  localparam int MAG_W = 50;
  localparam int DEN_W = 35;

  // Rotator widths: x and y in Q.30 with headroom, angle in radians Q.60.
  localparam int XW = 34;
  localparam int ZW = 63;

  // Two pi as pi times 2^30 in Q.29.
  localparam logic [31:0] TWO_PI_Q29 = 32'hC90FDAA2;

  // Configuration register indexes.
  localparam logic [2:0] REG_STEP_COUNT       = 3'd0;
  localparam logic [2:0] REG_MAIN_WAVE        = 3'd1;
  localparam logic [2:0] REG_FINE_WAVE        = 3'd2;
  localparam logic [2:0] REG_RADIUS_OFFSET    = 3'd3;
  localparam logic [2:0] REG_ANGLE_MULTIPLIER = 3'd4;
  localparam logic [2:0] REG_AMPLITUDE        = 3'd5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_MINOR_ZERO = 2'd2
  } status_t;

  // Per-request control that travels beside the datapath.
  typedef struct packed {
    logic    last;
    status_t status;
  } side_t;

  // Unsigned 64-bit quotient by shift and subtract, for elaboration-time constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = 65'd0;
    q = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in radians Q.60, i >= 1, by its alternating series.
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = 64'd1 << (60 - i);
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = udiv64(p, 64'(2 * k + 1));
        sum  = ((k & 1) == 1) ? sum - term : sum + term;
        p    = p >> (2 * i);
      end
    end
    return sum;
  endfunction

  // Arctangent of one third in radians Q.60.
  function automatic logic [63:0] atan_third();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = udiv64(64'd1 << 60, 64'd3);
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = udiv64(p, 64'(2 * k + 1));
        sum  = ((k & 1) == 1) ? sum - term : sum + term;
        p    = udiv64(p, 64'd9);
      end
    end
    return sum;
  endfunction

  // Rotation angle of stage i; the first stage turns by a quarter of pi.
  function automatic logic [63:0] stage_angle(input int i);
    if (i == 0) return atan_pow2(1) + atan_third();
    return atan_pow2(i);
  endfunction

  // Integer square root of a 64-bit value.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // Start value of x: the reciprocal of the rotator gain in Q.30.
  function automatic logic [63:0] cordic_x0(input int stages);
    logic [63:0] k2;
    k2 = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt64(k2);
  endfunction

endpackage

[sv/eptg_div_cell.sv]
// One restoring-division cell: shifts the remainder by a bit and subtracts the divisor if it fits.
module eptg_div_cell
  import eptg_pkg::*;
#(
  parameter int AUX_W    = MAG_W,
  parameter bit TAKE_BIT = 1'b1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] r_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [AUX_W-1:0] aux_in,
  output logic [DEN_W-1:0] r,
  output logic [DEN_W-1:0] den,
  output logic [AUX_W-1:0] aux
);

  logic [DEN_W:0] trial;
  logic           fits;
  logic [DEN_W:0] rem;

  // The new bit comes from the dividend in the modulo part and is zero in the fraction part.
  assign trial = {r_in, (TAKE_BIT ? aux_in[AUX_W-1] : 1'b0)};
  assign fits  = trial >= {1'b0, den_in};
  assign rem   = fits ? trial - {1'b0, den_in} : trial;

  // Hand remainder, divisor and the shifted word with the quotient bit on to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      r   <= rem[DEN_W-1:0];
      den <= den_in;
      aux <= {aux_in[AUX_W-2:0], fits};
    end
  end

endmodule

[sv/eptg_turn_chain.sv]
// Chain of division cells giving the fraction of a turn of a signed ratio.
module eptg_turn_chain
  import eptg_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_W-1:0]      mag,
  input  logic                  neg,
  input  logic [DEN_W-1:0]      den,
  output logic [PHASE_BITS-1:0] phase
);

  logic [DEN_W-1:0]      r_m   [MAG_W];
  logic [DEN_W-1:0]      den_m [MAG_W];
  logic [MAG_W-1:0]      aux_m [MAG_W];
  logic [MAG_W-1:0]      neg_line;
  logic [DEN_W-1:0]      r_f;
  logic [DEN_W-1:0]      den_f;
  logic [DEN_W-1:0]      r_q   [PHASE_BITS];
  logic [DEN_W-1:0]      den_q [PHASE_BITS];
  logic [PHASE_BITS-1:0] aux_q [PHASE_BITS];

  // Remainder of the magnitude, one dividend bit per cell, most significant first.
  for (genvar k = 0; k < MAG_W; k++) begin : g_mod
    eptg_div_cell #(.AUX_W(MAG_W), .TAKE_BIT(1'b1)) u_cell (
      .clk    (clk),
      .en     (en),
      .r_in   ((k == 0) ? {DEN_W{1'b0}} : r_m[k-1]),
      .den_in ((k == 0) ? den : den_m[k-1]),
      .aux_in ((k == 0) ? mag : aux_m[k-1]),
      .r      (r_m[k]),
      .den    (den_m[k]),
      .aux    (aux_m[k])
    );
  end

  // The sign waits beside the modulo cells.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_line <= {neg_line[MAG_W-2:0], neg};
    end
  end

  // A negative ratio turns the remainder into its complement against the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      r_f   <= (neg_line[MAG_W-1] && (r_m[MAG_W-1] != '0)) ?
               den_m[MAG_W-1] - r_m[MAG_W-1] : r_m[MAG_W-1];
      den_f <= den_m[MAG_W-1];
    end
  end

  // Fraction bits, one per cell.
  for (genvar k = 0; k < PHASE_BITS; k++) begin : g_frac
    eptg_div_cell #(.AUX_W(PHASE_BITS), .TAKE_BIT(1'b0)) u_cell (
      .clk    (clk),
      .en     (en),
      .r_in   ((k == 0) ? r_f : r_q[k-1]),
      .den_in ((k == 0) ? den_f : den_q[k-1]),
      .aux_in ((k == 0) ? {PHASE_BITS{1'b0}} : aux_q[k-1]),
      .r      (r_q[k]),
      .den    (den_q[k]),
      .aux    (aux_q[k])
    );
  end

  assign phase = aux_q[PHASE_BITS-1];

endmodule

[sv/eptg_cordic_cell.sv]
// One CORDIC rotation cell with its fixed shift and angle.
module eptg_cordic_cell
  import eptg_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [1:0]           quad_in,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic signed [ZW-1:0] z,
  output logic [1:0]           quad
);

  localparam logic signed [ZW-1:0] ANGLE = ZW'(stage_angle(IDX));

  // Rotate toward zero residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x <= x_in - (y_in >>> IDX);
        y <= y_in + (x_in >>> IDX);
        z <= z_in - ANGLE;
      end else begin
        x <= x_in + (y_in >>> IDX);
        y <= y_in - (x_in >>> IDX);
        z <= z_in + ANGLE;
      end
      quad <= quad_in;
    end
  end

endmodule

[sv/eptg_rotator.sv]
// Cosine and sine in Q.30 of a phase in turns: CORDIC cell chain with residual correction.
module eptg_rotator
  import eptg_pkg::*;
#(
  parameter int PHASE_BITS    = PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PHASE_BITS-1:0] phase,
  output logic signed [XW-1:0]  cos_v,
  output logic signed [XW-1:0]  sin_v
);

  localparam int SH  = 31 - PHASE_BITS;
  localparam int PW  = PHASE_BITS + 30;
  localparam int ZQW = ZW - 30;
  localparam logic signed [XW-1:0] X0 = XW'(cordic_x0(CORDIC_STAGES));

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [PW-1:0]        prod;
  logic signed [ZW-1:0] z_pre;
  logic signed [ZW-1:0] z0;
  logic [1:0]           quad0;
  logic signed [XW-1:0] x_c    [CORDIC_STAGES];
  logic signed [XW-1:0] y_c    [CORDIC_STAGES];
  logic signed [ZW-1:0] z_c    [CORDIC_STAGES];
  logic [1:0]           quad_c [CORDIC_STAGES];
  logic signed [ZQW-1:0]   zq;
  logic signed [XW+ZQW-1:0] pxz;
  logic signed [XW+ZQW-1:0] pyz;
  logic signed [XW-1:0] xh;
  logic signed [XW-1:0] yh;
  logic [1:0]           quadh;
  logic signed [XW-1:0] nx;
  logic signed [XW-1:0] ny;

  // Angle within the quadrant in radians Q.60.
  assign prod = PW'(phase[PHASE_BITS-3:0]) * PW'(TWO_PI_Q29);
  if (SH >= 0) begin : g_shl
    assign z_pre = $signed(ZW'(prod) << SH);
  end else begin : g_shr
    assign z_pre = $signed(ZW'(prod >> 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0    <= z_pre;
      quad0 <= phase[PHASE_BITS-1:PHASE_BITS-2];
    end
  end

  // Rotation cells.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    eptg_cordic_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .en      (en),
      .x_in    ((i == 0) ? X0 : x_c[i-1]),
      .y_in    ((i == 0) ? {XW{1'b0}} : y_c[i-1]),
      .z_in    ((i == 0) ? z0 : z_c[i-1]),
      .quad_in ((i == 0) ? quad0 : quad_c[i-1]),
      .x       (x_c[i]),
      .y       (y_c[i]),
      .z       (z_c[i]),
      .quad    (quad_c[i])
    );
  end

  // First-order correction for the residual angle: products first.
  assign zq = z_c[CORDIC_STAGES-1][ZW-1:30];

  always_ff @(posedge clk) begin
    if (en) begin
      pxz   <= x_c[CORDIC_STAGES-1] * zq;
      pyz   <= y_c[CORDIC_STAGES-1] * zq;
      xh    <= x_c[CORDIC_STAGES-1];
      yh    <= y_c[CORDIC_STAGES-1];
      quadh <= quad_c[CORDIC_STAGES-1];
    end
  end

  assign nx = xh - XW'(pyz >>> 30);
  assign ny = yh + XW'(pxz >>> 30);

  // Map back to the full turn by quadrant.
  always_ff @(posedge clk) begin
    if (en) begin
      case (quadh)
        QUAD_0: begin
          cos_v <= nx;
          sin_v <= ny;
        end
        QUAD_1: begin
          cos_v <= -ny;
          sin_v <= nx;
        end
        QUAD_2: begin
          cos_v <= -nx;
          sin_v <= -ny;
        end
        QUAD_3: begin
          cos_v <= ny;
          sin_v <= -nx;
        end
        default: begin
          cos_v <= nx;
          sin_v <= ny;
        end
      endcase
    end
  end

endmodule

[sv/epitrochoid_point_generator_core.sv]
// Top level of the epitrochoid point generator: configuration, phase pipeline and point assembly.
//
// The block takes one point index per clock and returns one point per index, in order. Each index
// passes a fixed pipeline of 7 + (50 + 1 + PHASE_BITS) + (CORDIC_STAGES + 3) register stages,
// 105 with the default parameters: an input register, two multiply stages, a chain of division
// cells that forms both phases one bit per cell (50 remainder cells, one sign fix stage and one
// cell per phase bit), a phase register and a chain of CORDIC cells with a correction and quadrant
// stage, and four stages that weight, sum, scale and round. The whole pipeline advances together
// and holds while a result waits at the output and the sink is not ready; an index with a bad
// range or a zero minor ripple still takes one slot and comes back flagged with zero coordinates.
module epitrochoid_point_generator_core
  import eptg_pkg::*;
#(
  parameter int MAX_STEPS     = MAX_STEPS_DEF,
  parameter int PHASE_BITS    = PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] point_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [21:0] x_coord, [43:22] y_coord
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int L_DIV = MAG_W + 1 + PHASE_BITS;
  localparam int L_ROT = CORDIC_STAGES + 3;
  localparam int D     = 6 + L_DIV + L_ROT;

  logic [11:0]        step_count;
  logic [14:0]        main_wave;
  logic [15:0]        fine_wave;
  logic signed [16:0] radius_offset;
  logic signed [15:0] angle_multiplier;
  logic [12:0]        amplitude;

  logic [11:0]        n_c;
  logic [14:0]        maj_c;
  logic [15:0]        mnr_c;
  logic signed [16:0] rad_c;
  logic signed [15:0] mul_c;
  logic [12:0]        amp_c;
  logic [23:0]        rr;
  logic signed [25:0] rp;

  logic               en;
  logic [11:0]        t_in;
  side_t              side_in;
  logic [11:0]        t0;
  side_t              side_line [D+1];
  logic [D:0]         vld;

  logic signed [28:0] mt1;
  logic [27:0]        nm1;
  logic signed [28:0] mt2;
  logic signed [53:0] num2;
  logic [DEN_W-1:0]   den2;
  logic [28:0]        abs1;
  logic [53:0]        abs2;
  logic [PHASE_BITS-1:0] ph1;
  logic [PHASE_BITS-1:0] ph2;
  logic signed [XW-1:0]  c1;
  logic signed [XW-1:0]  s1;
  logic signed [XW-1:0]  c2;
  logic signed [XW-1:0]  s2;

  logic signed [58:0] px1;
  logic signed [59:0] px2;
  logic signed [58:0] py1;
  logic signed [59:0] py2;
  logic signed [60:0] sumx;
  logic signed [60:0] sumy;
  logic signed [38:0] sx;
  logic signed [38:0] sy;
  logic signed [52:0] ax;
  logic signed [52:0] ay;
  logic signed [52:0] rx;
  logic signed [52:0] ry;
  logic [21:0]        x_q;
  logic [21:0]        y_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count       <= 12'd391;
      main_wave        <= 15'd5376;
      fine_wave        <= 16'd18350;
      radius_offset    <= 17'sd12032;
      angle_multiplier <= 16'sd435;
      amplitude        <= 13'd896;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_COUNT:       step_count       <= cfg_data[11:0];
        REG_MAIN_WAVE:        main_wave        <= cfg_data[14:0];
        REG_FINE_WAVE:        fine_wave        <= cfg_data[15:0];
        REG_RADIUS_OFFSET:    radius_offset    <= $signed(cfg_data[16:0]);
        REG_ANGLE_MULTIPLIER: angle_multiplier <= $signed(cfg_data[15:0]);
        REG_AMPLITUDE:        amplitude        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Registers clamped to their ranges; the user must keep them still while requests are in flight (not enforced here).
  always_comb begin
    n_c   = (step_count < 12'(MIN_STEPS)) ? 12'(MIN_STEPS) :
            (step_count > 12'(MAX_STEPS)) ? 12'(MAX_STEPS) : step_count;
    maj_c = (main_wave > 15'd25600) ? 15'd25600 : main_wave;
    mnr_c = (fine_wave > 16'd32768) ? 16'd32768 : fine_wave;
    rad_c = (radius_offset < -17'sd25600) ? -17'sd25600 :
            (radius_offset > 17'sd51200) ? 17'sd51200 : radius_offset;
    mul_c = (angle_multiplier < -16'sd25) ? -16'sd25 :
            (angle_multiplier > 16'sd25600) ? 16'sd25600 : angle_multiplier;
    amp_c = (amplitude < 13'd256) ? 13'd256 :
            (amplitude > 13'd5120) ? 13'd5120 : amplitude;
    rr    = 24'({maj_c, 8'b0}) + 24'(mnr_c);
    rp    = (26'(rad_c) <<< 8) + $signed({10'b0, mnr_c});
  end

  // The pipeline moves as one while the output slot is free or being taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Index check at the input.
  assign t_in = s_tdata[11:0];
  always_comb begin
    side_in.last = (t_in == n_c);
    if (t_in > n_c) begin
      side_in.status = ST_RANGE;
    end else if (mnr_c == 16'd0) begin
      side_in.status = ST_MINOR_ZERO;
    end else begin
      side_in.status = ST_OK;
    end
  end

  // Valid bits and control beside the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[D-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0           <= t_in;
      side_line[0] <= side_in;
      for (int k = 1; k <= D; k++) begin
        side_line[k] <= side_line[k-1];
      end
    end
  end

  // Phase numerators and denominators.
  always_ff @(posedge clk) begin
    if (en) begin
      mt1  <= mul_c * $signed({1'b0, t0});
      nm1  <= 28'(n_c) * 28'(mnr_c);
      mt2  <= mt1;
      num2 <= mt1 * $signed({1'b0, rr});
      den2 <= DEN_W'({nm1, 8'b0});
    end
  end

  assign abs1 = mt2[28] ? 29'(-mt2) : 29'(mt2);
  assign abs2 = num2[53] ? 54'(-num2) : 54'(num2);

  eptg_turn_chain #(.PHASE_BITS(PHASE_BITS)) u_turn1 (
    .clk   (clk),
    .en    (en),
    .mag   (MAG_W'(abs1)),
    .neg   (mt2[28]),
    .den   (DEN_W'({n_c, 8'b0})),
    .phase (ph1)
  );

  eptg_turn_chain #(.PHASE_BITS(PHASE_BITS)) u_turn2 (
    .clk   (clk),
    .en    (en),
    .mag   (MAG_W'(abs2)),
    .neg   (num2[53]),
    .den   (den2),
    .phase (ph2)
  );

  eptg_rotator #(.PHASE_BITS(PHASE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_rot1 (
    .clk   (clk),
    .en    (en),
    .phase (ph1),
    .cos_v (c1),
    .sin_v (s1)
  );

  eptg_rotator #(.PHASE_BITS(PHASE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_rot2 (
    .clk   (clk),
    .en    (en),
    .phase (ph2),
    .cos_v (c2),
    .sin_v (s2)
  );

  // Weighted sum in Q.46, floored to Q.24, scaled, then rounded half up to Q.8.
  assign sumx = 61'(px1) + 61'(px2);
  assign sumy = 61'(py1) + 61'(py2);
  assign rx   = ax + 53'sd8388608;
  assign ry   = ay + 53'sd8388608;

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= $signed({1'b0, rr}) * c1;
      px2 <= rp * c2;
      py1 <= $signed({1'b0, rr}) * s1;
      py2 <= rp * s2;
      sx  <= sumx[60:22];
      sy  <= sumy[60:22];
      ax  <= $signed({1'b0, amp_c}) * sx;
      ay  <= $signed({1'b0, amp_c}) * sy;
      if (side_line[D-1].status == ST_OK) begin
        x_q <= rx[45:24];
        y_q <= ry[45:24];
      end else begin
        x_q <= 22'd0;
        y_q <= 22'd0;
      end
    end
  end

  assign m_tvalid = vld[D];
  assign m_tdata  = {4'b0, y_q, x_q};
  assign m_tlast  = side_line[D].last;
  assign m_tuser  = side_line[D].status;

  // A flagged result carries zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[43:0] == 44'd0))
    else $error("flagged result with nonzero coordinates");

  // The closing index is never beyond the step count.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser != ST_RANGE))
    else $error("last point flagged as out of range");

  // An accepted request occupies the first pipeline slot.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted request lost at pipeline entry");

endmodule

[tb/epitrochoid_point_generator_core_tb.sv]
// Self-checking testbench for the epitrochoid point generator core.
module epitrochoid_point_generator_core_tb;
  import eptg_pkg::*;

  typedef struct {
    logic [21:0] x;
    logic [21:0] y;
    logic        last;
    status_t     status;
  } point_t;

  // Bit-exact point predictor with its own register copy and a queue of pending points.
  class point_scoreboard;
    longint regs[6];
    longint stage_ang[20];
    longint x_start;
    point_t pending[$];
    int     errors;

    function new();
      longint unsigned k2;
      regs = '{391, 5376, 18350, 12032, 435, 896};
      errors = 0;
      for (int i = 0; i < 20; i++) begin
        stage_ang[i] = (i == 0) ? arctan_recip(2) + arctan_recip(3) : arctan_recip(64'd1 << i);
      end
      k2 = 64'd1 << 60;
      for (int i = 0; i < 20; i++) k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
      x_start = longint'(int_sqrt(k2));
    endfunction

    function longint arctan_recip(longint unsigned n);
      longint unsigned p;
      longint unsigned nn;
      longint          sum;
      longint          term;
      longint unsigned k;
      p = (64'd1 << 60) / n;
      nn = n * n;
      sum = 0;
      k = 0;
      while (p != 0) begin
        term = longint'(p / (2 * k + 1));
        sum = k[0] ? sum - term : sum + term;
        p = p / nn;
        k++;
      end
      return sum;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v_in);
      longint unsigned v;
      longint unsigned res;
      longint unsigned b;
      v = v_in;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Fraction of a turn of num/den, floored to 24 bits.
    function longint unsigned turn_fraction(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned r;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : num;
      r = mag % den;
      q = 0;
      if (num < 0 && r != 0) r = den - r;
      for (int b = 0; b < 24; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    // Cosine and sine in Q.30 of a 24-bit phase, by rotation plus residual correction.
    function void rotate(longint unsigned ph, output longint c, output longint s);
      longint x, y, z, nx, ny, zq;
      logic [1:0] quad;
      quad = ph[23:22];
      z = longint'((ph & 64'h3FFFFF) * 64'hC90FDAA2) <<< 7;
      x = x_start;
      y = 0;
      for (int i = 0; i < 20; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z = z - stage_ang[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z = z + stage_ang[i];
        end
        x = nx;
        y = ny;
      end
      zq = z >>> 30;
      nx = x - ((y * zq) >>> 30);
      ny = y + ((x * zq) >>> 30);
      case (quad)
        2'd0: begin c = nx;  s = ny;  end
        2'd1: begin c = -ny; s = nx;  end
        2'd2: begin c = -nx; s = -ny; end
        default: begin c = ny; s = -nx; end
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Register write: keep the raw value at the register's width.
    function void write_reg(int index, logic [16:0] value);
      int     w;
      longint v;
      if (index > 5) return;
      w = (index == 0) ? 12 : (index == 1) ? 15 : (index == 2) ? 16 :
          (index == 3) ? 17 : (index == 4) ? 16 : 13;
      v = value & ((64'd1 << w) - 1);
      if ((index == 3 || index == 4) && v[w-1]) v = v - (64'sd1 << w);
      regs[index] = v;
    endfunction

    // Accepted request: work out the point it must produce.
    function void note_request(logic [11:0] t_in);
      longint t, n, maj, mnr, rad, mul, amp, rr, rp, c1, s1, c2, s2, xs, ys;
      longint unsigned ph1, ph2;
      point_t p;
      t = t_in;
      n = clamp(regs[0], 10, 3000);
      maj = clamp(regs[1], 0, 25600);
      mnr = clamp(regs[2], 0, 32768);
      rad = clamp(regs[3], -25600, 51200);
      mul = clamp(regs[4], -25, 25600);
      amp = clamp(regs[5], 256, 5120);
      p.status = (t > n) ? ST_RANGE : (mnr == 0) ? ST_MINOR_ZERO : ST_OK;
      p.last = (t == n);
      p.x = '0;
      p.y = '0;
      if (p.status == ST_OK) begin
        rr = maj * 256 + mnr;
        rp = rad * 256 + mnr;
        ph1 = turn_fraction(mul * t, 256 * n);
        ph2 = turn_fraction(mul * t * rr, 256 * n * mnr);
        rotate(ph1, c1, s1);
        rotate(ph2, c2, s2);
        xs = (amp * ((rr * c1 + rp * c2) >>> 22) + (64'sd1 << 23)) >>> 24;
        ys = (amp * ((rr * s1 + rp * s2) >>> 22) + (64'sd1 << 23)) >>> 24;
        p.x = xs[21:0];
        p.y = ys[21:0];
      end
      pending.push_back(p);
    endfunction

    // Accepted point: compare with the oldest pending one.
    function void check_point(logic [47:0] data, logic last, logic [1:0] user);
      point_t e;
      if (pending.size() == 0) begin
        $error("point with no pending request: data %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[21:0] !== e.x) begin
        $error("x_coord expected %h actual %h", e.x, data[21:0]);
        errors++;
      end
      if (data[43:22] !== e.y) begin
        $error("y_coord expected %h actual %h", e.y, data[43:22]);
        errors++;
      end
      if (last !== e.last) begin
        $error("is_last expected %b actual %b", e.last, last);
        errors++;
      end
      if (user !== e.status) begin
        $error("status expected %0d actual %0d", e.status, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  point_scoreboard sb;
  bit quiet;
  int hold_cycles;
  int steps_now;

  epitrochoid_point_generator_core dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  task automatic write_cfg(logic [2:0] index, logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(index, value);
  endtask

  task automatic set_all(int st, int ma, int mi, int ra, int mu, int am);
    write_cfg(REG_STEP_COUNT, st);
    write_cfg(REG_MAIN_WAVE, ma);
    write_cfg(REG_FINE_WAVE, mi);
    write_cfg(REG_RADIUS_OFFSET, ra);
    write_cfg(REG_ANGLE_MULTIPLIER, mu);
    write_cfg(REG_AMPLITUDE, am);
    steps_now = (sb.regs[0] < 10) ? 10 : (sb.regs[0] > 3000) ? 3000 : int'(sb.regs[0]);
  endtask

  // Send one request, with an occasional idle burst first.
  task automatic send_index(logic [11:0] idx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_request(idx);
  endtask

  task automatic send_random(int count);
    logic [11:0] idx;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0: idx = steps_now;
        1: idx = $urandom_range(steps_now + 1, 4095);
        2: idx = 0;
        default: idx = $urandom_range(0, steps_now);
      endcase
      send_index(idx);
    end
  endtask

  // Let the pipeline empty before touching the registers.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Sink side: random ready bursts and one long hold when requested.
  initial begin
    int stall;
    stall = 0;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_point(m_tdata, m_tlast, m_tuser);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    quiet = 0;
    hold_cycles = 0;
    steps_now = 391;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points on reset settings: range ends, closing point, indexes beyond it.
    send_index(0);
    send_index(1);
    send_index(390);
    send_index(391);
    send_index(392);
    send_index(12'hFFF);
    send_index(12'hAAA);
    send_index(12'h555);
    send_index(200);
    drain();

    // Lower extremes; the sink holds off long enough to back up the pipeline.
    set_all(10, 0, 32768, -25600, -25, 256);
    hold_cycles = 300;
    send_index(10);
    send_index(11);
    send_random(150);
    drain();

    // Upper extremes.
    set_all(3000, 25600, 1, 51200, 25600, 5120);
    send_index(3000);
    send_index(3001);
    send_index(2999);
    send_random(70);
    drain();

    // Zero minor ripple, including the clash with an index beyond range.
    set_all(500, 1000, 0, 100, 300, 1000);
    send_index(500);
    send_index(501);
    send_random(20);
    drain();

    // Raw values outside the allowed ranges are clamped on use.
    set_all(4095, 32767, 65535, 17'h10000, 17'h08000, 0);
    send_index(3000);
    send_index(3001);
    send_index(4095);
    drain();
    set_all(0, 0, 1, 17'h0FFFF, 17'h07FFF, 8191);
    send_random(30);
    drain();

    // Random settings; the last one runs without any idling.
    for (int ph = 0; ph < 4; ph++) begin
      set_all($urandom_range(10, 3000), $urandom_range(0, 25600), $urandom_range(1, 32768),
              $urandom_range(0, 76800) - 25600, $urandom_range(0, 25625) - 25,
              $urandom_range(256, 5120));
      if (ph == 3) quiet = 1;
      send_random(60);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
